// File: rtl/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 7;

  localparam int QA = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(2 * WINDOW_MAX);

  typedef logic [QA-1:0]                 qptr_t;
  typedef logic [CW-1:0]                 cnt_t;
  typedef logic [PW-1:0]                 pos_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic load;   // take in_sample / in_first, restart on first
    logic pop;    // remove tail entry
    logic push;   // append held sample at tail
    logic drop;   // remove front entry
    logic emit;   // front value to output register
    logic adv;    // advance stream position
  } swm_cmd_t;

  typedef struct packed {
    logic back_lt;   // queue not empty and tail value below held sample
    logic seen_lt;   // window not yet filled
    logic stale;     // front entry outside a shrunk window
    logic last_age;  // front entry leaves with this result
    logic out_free;  // output register can take a result
  } swm_stat_t;

  function automatic qptr_t ptr_inc(qptr_t p);
    return (p == qptr_t'(WINDOW_MAX - 1)) ? '0 : qptr_t'(p + 1'b1);
  endfunction

  function automatic qptr_t ptr_dec(qptr_t p);
    return (p == '0) ? qptr_t'(WINDOW_MAX - 1) : qptr_t'(p - 1'b1);
  endfunction

  function automatic pos_t pos_inc(pos_t p);
    return (p == pos_t'(2 * WINDOW_MAX - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

  // distance from entry position p to current position, modulo 2*WINDOW_MAX
  function automatic pos_t pos_age(pos_t cur, pos_t p);
    logic [PW:0] t;
    t = {1'b0, cur} + (PW+1)'(2 * WINDOW_MAX) - {1'b0, p};
    return (cur >= p) ? pos_t'(cur - p) : pos_t'(t);
  endfunction

endpackage

// File: rtl/sliding_window_maximum.sv
// Sliding window maximum over the last window_size signed samples.
// Input channel: in_valid / in_stall with in_sample and in_first. A transfer
// with in_first high empties the window and restarts the stream at that sample.
// Output channel: out_valid / out_stall with out_window_max, one result per
// sample once the window has filled, none before.
// Config channel: cfg_valid / cfg_ready with cfg_window_size; cfg_ready is
// always high. Write it only while the block is idle. 0 acts as 1, values
// above the queue depth act as the depth.
// Timing: one sample at a time. After a transfer the block waits on the tail
// read, pops each smaller entry from the queue tail, pushes the sample, waits
// on the front read, drops each stale front entry after a window shrink and
// then emits any result; every queue step waits on the registered read of the
// queue memory.
// The result sits in an output register; if it is still stalled when the next
// result is ready, the block holds that result and stalls its input.
// Reset (rst_n low, synchronous) empties the queue, clears the counters and
// sets window_size to 1. No clearing pass is needed.
module sliding_window_maximum import swm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_first,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_window_max,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_BITS-1:0]    cfg_window_size
);

  swm_cmd_t  cmd;
  swm_stat_t stat;

  assign cfg_ready = 1'b1;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_first        (in_first),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_window_size (cfg_window_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_max  (out_window_max),
    .cmd             (cmd),
    .stat            (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  a_one_queue_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.pop, cmd.push, cmd.emit}))
    else $error("conflicting queue commands");

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

// File: rtl/swm_ctrl.sv
module swm_ctrl import swm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  swm_stat_t stat,
  output swm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WAITB  = 3'd1;
  localparam logic [2:0] S_POPCHK = 3'd2;
  localparam logic [2:0] S_WAITF  = 3'd3;
  localparam logic [2:0] S_FRCHK  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WAITB;
        end
      end
      // registered memory read of the tail entry settles here
      S_WAITB: state_nxt = S_POPCHK;
      S_POPCHK: begin
        if (stat.back_lt) begin
          cmd.pop   = 1'b1;
          state_nxt = S_WAITB;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_WAITF;
        end
      end
      S_WAITF: state_nxt = S_FRCHK;
      S_FRCHK: begin
        priority if (stat.seen_lt) begin
          cmd.adv   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.stale) begin
          cmd.drop  = 1'b1;
          state_nxt = S_WAITF;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.drop  = stat.last_age;
          cmd.adv   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // result register still stalled
          state_nxt = S_FRCHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/swm_dp.sv
module swm_dp import swm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_first,
  input  logic                   cfg_valid,
  input  logic [CFG_BITS-1:0]    cfg_window_size,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_window_max,
  input  swm_cmd_t               cmd,
  output swm_stat_t              stat
);

  logic [SAMPLE_BITS-1:0] val_mem [WINDOW_MAX];
  pos_t                   pos_mem [WINDOW_MAX];

  logic [CFG_BITS-1:0] cfg_r;
  sample_t             sample_r;
  qptr_t               head_r, head_nxt;
  qptr_t               tail_r, tail_nxt;
  cnt_t                count_r, count_nxt;
  pos_t                pos_r, pos_nxt;
  cnt_t                seen_r, seen_nxt;
  sample_t             back_q;
  logic [SAMPLE_BITS-1:0] front_val_q;
  pos_t                front_pos_q;
  logic                out_valid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;

  cnt_t k;
  pos_t age;

  always_comb begin
    if (cfg_r == '0) begin
      k = cnt_t'(1);
    end else if (int'(cfg_r) > WINDOW_MAX) begin
      k = cnt_t'(WINDOW_MAX);
    end else begin
      k = cnt_t'(cfg_r);
    end
  end

  assign age = pos_age(pos_r, front_pos_q);

  assign stat.back_lt  = (count_r != '0) && (back_q < sample_r);
  assign stat.seen_lt  = (seen_r < k);
  assign stat.stale    = (count_r > cnt_t'(1)) && (age >= pos_t'(k));
  assign stat.last_age = (age == pos_t'(k - 1'b1));
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    if (cmd.load && in_first) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      pos_nxt   = '0;
      seen_nxt  = '0;
    end
    if (cmd.pop) begin
      tail_nxt  = ptr_dec(tail_r);
      count_nxt = cnt_t'(count_r - 1'b1);
    end
    if (cmd.push) begin
      tail_nxt = ptr_inc(tail_r);
      // full queue: oldest entry makes room
      if (count_r == cnt_t'(WINDOW_MAX)) begin
        head_nxt = ptr_inc(head_r);
      end else begin
        count_nxt = cnt_t'(count_r + 1'b1);
      end
      if (seen_r < k) begin
        seen_nxt = cnt_t'(seen_r + 1'b1);
      end
    end
    if (cmd.drop && (count_r != '0)) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = cnt_t'(count_r - 1'b1);
    end
    if (cmd.adv) begin
      pos_nxt = pos_inc(pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_BITS'(1);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_window_size;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample_t'(in_sample);
    end
    if (cmd.emit) begin
      out_data_r <= front_val_q;
    end
  end

  // queue storage: one write port at the tail, reads at tail-1 and head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_mem[tail_r] <= sample_r;
      pos_mem[tail_r] <= pos_r;
    end
    back_q      <= sample_t'(val_mem[ptr_dec(tail_r)]);
    front_val_q <= val_mem[head_r];
    front_pos_q <= pos_mem[head_r];
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_data_r;

endmodule
